>>> design/uniform_grid_broadphase_top_macros.svh
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: assertion macros
// Immediate-consequence and next-cycle property macros for the grid block.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_BROADPHASE_TOP_MACROS_SVH
`define UNIFORM_GRID_BROADPHASE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define UGB_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uniform grid broad-phase assertion failed");

// Consequent must hold in the cycle after the antecedent
`define UGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uniform grid broad-phase assertion failed");

`else

`define UGB_ASSERT(label, clk, rst_n, ante, cons)
`define UGB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/ugb_pkg.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: package
// Field widths, request codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package ugb_pkg;

    // Field widths
    localparam int REQ_TYPE_W = 2;
    localparam int OBJ_ID_W   = 6;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 12;
    localparam int HIT_W      = 64;

    // Divider: far corner is one bit wider than a coordinate
    localparam int QUOT_W    = COORD_W + 1;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Cell index wide enough for the largest grid edge (256)
    localparam int CELL_W = 8;

    // Command queue between front and back
    localparam int CMD_Q_DEPTH = 2;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 12'd64;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;

    typedef logic [CELL_W-1:0] t_cell;

    // Classified request with its covered cell range
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] kind;
        logic [OBJ_ID_W-1:0]   id;
        logic                  touch;
        t_cell                 x0;
        t_cell                 y0;
        t_cell                 x1;
        t_cell                 y1;
    } t_cmd;

endpackage

>>> design/ugb_ifs.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ugb_req_if;
    logic                             valid;
    logic                             ready;
    logic [ugb_pkg::REQ_TYPE_W-1:0]   req_type;
    logic [ugb_pkg::OBJ_ID_W-1:0]     object_id;
    logic [ugb_pkg::COORD_W-1:0]      rect_x;
    logic [ugb_pkg::COORD_W-1:0]      rect_y;
    logic [ugb_pkg::COORD_W-1:0]      rect_w;
    logic [ugb_pkg::COORD_W-1:0]      rect_h;

    modport source (
        output valid, req_type, object_id, rect_x, rect_y, rect_w, rect_h,
        input  ready
    );
    modport sink (
        input  valid, req_type, object_id, rect_x, rect_y, rect_w, rect_h,
        output ready
    );
endinterface

interface ugb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ugb_pkg::HIT_W-1:0]   hit_mask;
    logic                        req_done;

    modport source (
        output valid, hit_mask, req_done,
        input  ready
    );
    modport sink (
        input  valid, hit_mask, req_done,
        output ready
    );
endinterface

>>> design/ugb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: command queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ugb_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ugb_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ugb_pkg::t_cmd o_data,
    output logic          o_empty
);

    localparam int DEPTH = ugb_pkg::CMD_Q_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ugb_pkg::t_cmd   r_q [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_q[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/ugb_front.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: front end
// Accepts requests, holds the cell size register, divides the four corner
// coordinates one quotient bit per cycle and queues a classified command.
// ----------------------------------------------------------------------------
module ugb_front #(
    parameter int GRID_W      = 32,
    parameter int GRID_H      = 32,
    parameter int MAX_OBJECTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ugb_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic                         i_clearing,
    ugb_req_if.sink                      i_req,
    output logic                         o_push,
    output ugb_pkg::t_cmd                o_cmd,
    input  logic                         i_full
);

    localparam int QW    = ugb_pkg::QUOT_W;
    localparam int RW    = ugb_pkg::SIZE_W;
    localparam int LANES = 4;
    localparam logic [ugb_pkg::OBJ_ID_W:0] MaxObj = (ugb_pkg::OBJ_ID_W + 1)'(MAX_OBJECTS);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state                              r_state;
    logic [RW-1:0]                       r_cell_size;
    logic [ugb_pkg::REQ_TYPE_W-1:0]      r_kind;
    logic [ugb_pkg::OBJ_ID_W-1:0]        r_id;
    logic [ugb_pkg::STEP_W-1:0]          r_step;
    logic [RW-1:0]                       r_rem [LANES];
    logic [QW-1:0]                       r_dq  [LANES];

    logic [RW-1:0]                       divisor;
    logic [QW-1:0]                       trial [LANES];
    logic                                ge    [LANES];
    logic [RW-1:0]                       n_rem [LANES];
    logic [QW-1:0]                       n_dq  [LANES];
    logic                                accept;
    logic                                is_rmw;

    // Clamp a quotient to the last row or column
    function automatic ugb_pkg::t_cell sat_cell(input logic [QW-1:0] q, input int lim);
        return (q >= QW'(lim)) ? ugb_pkg::t_cell'(lim - 1) : ugb_pkg::t_cell'(q);
    endfunction

    // A zero cell size counts as one
    assign divisor = (r_cell_size == '0) ? RW'(1) : r_cell_size;

    assign i_req.ready = (r_state == S_IDLE) && !i_clearing;
    assign accept      = i_req.valid && i_req.ready;

    // One restoring division step per lane
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            trial[k] = {r_rem[k], r_dq[k][QW-1]};
            ge[k]    = (trial[k] >= {1'b0, divisor});
            n_rem[k] = ge[k] ? RW'(trial[k] - {1'b0, divisor}) : trial[k][RW-1:0];
            n_dq[k]  = {r_dq[k][QW-2:0], ge[k]};
        end
    end

    // Classify and build the command from the finished quotients
    assign is_rmw = (r_kind == ugb_pkg::REQ_INSERT) || (r_kind == ugb_pkg::REQ_REMOVE);

    always_comb begin
        o_cmd.kind  = r_kind;
        o_cmd.id    = r_id;
        o_cmd.touch = is_rmw && ({1'b0, r_id} < MaxObj);
        o_cmd.x0    = sat_cell(r_dq[0], GRID_W);
        o_cmd.y0    = sat_cell(r_dq[1], GRID_H);
        o_cmd.x1    = sat_cell(r_dq[2], GRID_W);
        o_cmd.y1    = sat_cell(r_dq[3], GRID_H);
    end

    assign o_push = (r_state == S_PUSH) && !i_full;

    // Sequence accept, divide and push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell_size <= ugb_pkg::CELL_SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cell_size <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_req.req_type;
                        r_id   <= i_req.object_id;
                        r_dq[0] <= QW'(i_req.rect_x);
                        r_dq[1] <= QW'(i_req.rect_y);
                        r_dq[2] <= QW'(i_req.rect_x) + QW'(i_req.rect_w);
                        r_dq[3] <= QW'(i_req.rect_y) + QW'(i_req.rect_h);
                        for (int k = 0; k < LANES; k++) begin
                            r_rem[k] <= '0;
                        end
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < LANES; k++) begin
                        r_rem[k] <= n_rem[k];
                        r_dq[k]  <= n_dq[k];
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == ugb_pkg::STEP_W'(ugb_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/ugb_back.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: back end
// Owns the cell mask memory, clears it after reset, walks the covered cells
// of each walking command (read-modify-write for insert and remove, read only for query) and holds the result register.
// ----------------------------------------------------------------------------
`include "uniform_grid_broadphase_top_macros.svh"

module ugb_back #(
    parameter int GRID_W      = 32,
    parameter int GRID_H      = 32,
    parameter int MAX_OBJECTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ugb_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    ugb_rsp_if.source     o_rsp
);

    localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_MOD, S_FIN} t_state;

    t_state                        r_state;
    ugb_pkg::t_cmd                 r_cmd;
    logic [XW-1:0]                 r_cx;
    logic [YW-1:0]                 r_cy;
    logic [MAX_OBJECTS-1:0]        r_hits;
    logic [AW-1:0]                 r_clr;
    logic                          r_out_valid;
    logic [ugb_pkg::HIT_W-1:0]     r_out_hits;
    logic                          r_out_done;
    logic [MAX_OBJECTS-1:0]        r_mem [DEPTH];
    logic [MAX_OBJECTS-1:0]        r_rdata;

    logic [AW-1:0]                 cell_addr;
    logic [MAX_OBJECTS-1:0]        obj_bit;
    logic                          walk;
    logic                          row_end;
    logic                          col_end;
    logic                          out_free;
    logic                          in_range;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [MAX_OBJECTS-1:0]        mem_wdata;

    assign cell_addr = AW'(int'(r_cy) * GRID_W + int'(r_cx));
    assign obj_bit   = MAX_OBJECTS'(1) << r_cmd.id;
    assign walk      = (i_cmd.kind == ugb_pkg::REQ_QUERY) || i_cmd.touch;
    assign row_end   = (r_cy == r_cmd.y1[YW-1:0]);
    assign col_end   = (r_cx == r_cmd.x1[XW-1:0]);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign in_range  = (r_cx >= r_cmd.x0[XW-1:0]) && (r_cx <= r_cmd.x1[XW-1:0]) &&
                       (r_cy >= r_cmd.y0[YW-1:0]) && (r_cy <= r_cmd.y1[YW-1:0]);

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_clearing = (r_state == S_CLEAR);

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.hit_mask = r_out_hits;
    assign o_rsp.req_done = r_out_done;

    // Select the memory write: zero during the clearing pass, else set or drop the bit
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = r_rdata;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_MOD: begin
                if (r_cmd.touch) begin
                    mem_we = 1'b1;
                    if (r_cmd.kind == ugb_pkg::REQ_INSERT) begin
                        mem_wdata = r_rdata | obj_bit;
                    end else begin
                        mem_wdata = r_rdata & ~obj_bit;
                    end
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Cell mask memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[cell_addr];
        end
    end

    // Clear, walk the cell range and hand over the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_cx    <= i_cmd.x0[XW-1:0];
                        r_cy    <= i_cmd.y0[YW-1:0];
                        r_hits  <= '0;
                        r_state <= walk ? S_RD : S_FIN;
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_cmd.kind == ugb_pkg::REQ_QUERY) begin
                        r_hits <= r_hits | r_rdata;
                    end
                    if (row_end) begin
                        r_cy <= r_cmd.y0[YW-1:0];
                        if (col_end) begin
                            r_state <= S_FIN;
                        end else begin
                            r_cx    <= r_cx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_cy    <= r_cy + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hits  <= ugb_pkg::HIT_W'(r_hits);
                        r_out_done  <= (r_cmd.kind == ugb_pkg::REQ_INSERT) ||
                                       (r_cmd.kind == ugb_pkg::REQ_REMOVE) ||
                                       (r_cmd.kind == ugb_pkg::REQ_QUERY);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Finished result lands in the output register on the next edge
    `UGB_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, (r_state == S_FIN && out_free), (r_out_valid && r_state == S_IDLE))
    // Walk stays inside the covered rectangle
    `UGB_ASSERT(a_walk_in_range, i_clk, i_rst_n, (r_state == S_RD || r_state == S_MOD), in_range)
    // Queries never modify the memory
    `UGB_ASSERT(a_query_no_write, i_clk, i_rst_n, (r_state == S_MOD && r_cmd.kind == ugb_pkg::REQ_QUERY), !mem_we)
    // Unknown requests, and inserts or removes with out-of-range ids, never start a walk
    `UGB_ASSERT(a_walk_needed, i_clk, i_rst_n, (r_state == S_RD), (r_cmd.kind == ugb_pkg::REQ_QUERY || r_cmd.touch))

endmodule

>>> design/uniform_grid_broadphase_top.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: top level
// Fixed grid of per-cell occupancy masks for collision broad-phase insert,
// remove and query of axis-aligned rectangles.
//
//   channel   dir   handshake          payload
//   i_req     in    valid / ready      req_type, object_id, rect_x/y/w/h
//   o_rsp     out   valid / ready      hit_mask, req_done
//   cfg       in    i_cfg_we           i_cfg_wdata (cell_size)
//
// The front divides all four corner coordinates in parallel, one quotient bit
// per cycle. For each covered cell the back does one memory read, then one
// write or merge, so the sustained rate is set by the slower of the two.
// After reset a clearing pass zeroes all GRID_W*GRID_H cells (1024 by default)
// of the mask memory before the first transfer is taken.
// A two-entry command queue lets the front and back stall independently.
// ----------------------------------------------------------------------------
module uniform_grid_broadphase_top #(
    parameter int GRID_W      = 32,
    parameter int GRID_H      = 32,
    parameter int MAX_OBJECTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ugb_pkg::SIZE_W-1:0]   i_cfg_wdata,
    ugb_req_if.sink                      i_req,
    ugb_rsp_if.source                    o_rsp
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          clearing;
    ugb_pkg::t_cmd cmd_in;
    ugb_pkg::t_cmd cmd_out;

    // Accept and divide
    ugb_front #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_clearing  (clearing),
        .i_req       (i_req),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full)
    );

    // Decouple front and back
    ugb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (empty)
    );

    // Walk cells and answer
    ugb_back #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Uniform grid broad-phase: testbench
// Drives insert, remove and query requests, and some requests of no known
// kind, through the request channel. A grid occupancy predictor works out
// each expected response. Every response transfer is checked in order
// against it. Cell size is changed between phases while the block is idle,
// and random gaps are placed on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W        = 32;
    localparam int GRID_H        = 32;
    localparam int MAX_OBJECTS   = 64;
    localparam int COORD_MAX     = (1 << ugb_pkg::COORD_W) - 1;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 229;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int MAX_REPORTS   = 200;

    // Request code that the block does not know
    localparam logic [ugb_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef logic [ugb_pkg::COORD_W-1:0]  t_coord;
    typedef logic [ugb_pkg::OBJ_ID_W-1:0] t_obj_id;

    typedef struct packed {
        logic [ugb_pkg::REQ_TYPE_W-1:0] kind;
        logic [ugb_pkg::OBJ_ID_W-1:0]   id;
        logic [ugb_pkg::COORD_W-1:0]    rect_x;
        logic [ugb_pkg::COORD_W-1:0]    rect_y;
        logic [ugb_pkg::COORD_W-1:0]    rect_w;
        logic [ugb_pkg::COORD_W-1:0]    rect_h;
    } t_grid_req;

    typedef struct packed {
        logic [ugb_pkg::HIT_W-1:0] hit_mask;
        logic                      req_done;
    } t_grid_reply;

    // Occupancy predictor and the responses still owed by the block
    class t_occupancy_model;
        logic [ugb_pkg::HIT_W-1:0]  occupancy [GRID_W*GRID_H];
        logic [ugb_pkg::SIZE_W-1:0] edge_len;
        t_grid_reply                pending_replies [$];
        int                         errors;

        function new();
            foreach (occupancy[i]) occupancy[i] = '0;
            edge_len = ugb_pkg::CELL_SIZE_RESET;
            errors   = 0;
        endfunction

        function void set_edge(logic [ugb_pkg::SIZE_W-1:0] value);
            edge_len = value;
        endfunction

        function bit idle();
            return pending_replies.size() == 0;
        endfunction

        // Truncating division; a zero edge counts as one; saturate at the last cell
        function int unsigned cell_index(int unsigned coord, int unsigned last);
            int unsigned span;
            int unsigned c;
            span = (edge_len == 0) ? 1 : 32'(edge_len);
            c = coord / span;
            return (c > last) ? last : c;
        endfunction

        // Apply an accepted request to the grid and note its response
        function void take_request(t_grid_req r);
            int unsigned               x0, y0, x1, y1, far_x, far_y;
            logic [ugb_pkg::HIT_W-1:0] hits;
            logic [ugb_pkg::HIT_W-1:0] id_bit;
            t_grid_reply               want;
            if (r.kind == REQ_UNKNOWN) begin
                want.hit_mask = '0;
                want.req_done = 1'b0;
                pending_replies.push_back(want);
                return;
            end
            far_x  = 32'(r.rect_x) + 32'(r.rect_w);
            far_y  = 32'(r.rect_y) + 32'(r.rect_h);
            x0     = cell_index(32'(r.rect_x), GRID_W - 1);
            y0     = cell_index(32'(r.rect_y), GRID_H - 1);
            x1     = cell_index(far_x, GRID_W - 1);
            y1     = cell_index(far_y, GRID_H - 1);
            hits   = '0;
            id_bit = (r.id < MAX_OBJECTS) ? (64'd1 << r.id) : '0;
            for (int unsigned cx = x0; cx <= x1; cx++) begin
                for (int unsigned cy = y0; cy <= y1; cy++) begin
                    if (r.kind == ugb_pkg::REQ_QUERY)
                        hits |= occupancy[cy*GRID_W + cx];
                    else if (r.kind == ugb_pkg::REQ_INSERT)
                        occupancy[cy*GRID_W + cx] |= id_bit;
                    else
                        occupancy[cy*GRID_W + cx] &= ~id_bit;
                end
            end
            want.hit_mask = hits;
            want.req_done = 1'b1;
            pending_replies.push_back(want);
        endfunction

        // Compare a response transfer with the oldest one owed
        function void check_reply(logic [ugb_pkg::HIT_W-1:0] hit, logic done);
            t_grid_reply want;
            if (pending_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: response with none owed: hit_mask %h req_done %b",
                             $time, hit, done);
                return;
            end
            want = pending_replies.pop_front();
            if (hit !== want.hit_mask) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: hit_mask expected %h actual %h",
                             $time, want.hit_mask, hit);
            end
            if (done !== want.req_done) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: req_done expected %b actual %b",
                             $time, want.req_done, done);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ugb_pkg::SIZE_W-1:0] i_cfg_wdata;

    ugb_req_if req_ch ();
    ugb_rsp_if rsp_ch ();

    t_occupancy_model grid;
    bit calm;
    int rsp_stall   = 0;
    int cycle_count = 0;

    uniform_grid_broadphase_top #(
        .GRID_W      (GRID_W),
        .GRID_H      (GRID_H),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int next_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Response side: check each transfer, stall ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            grid.check_reply(rsp_ch.hit_mask, rsp_ch.req_done);
        if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = rsp_stall - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = next_gap();
        end
    end

    // Abandon a run that has hung
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one request after a random gap and hold it until the transfer
    task automatic send_request(logic [ugb_pkg::REQ_TYPE_W-1:0] kind,
                                logic [ugb_pkg::OBJ_ID_W-1:0] id,
                                t_coord x, t_coord y, t_coord w, t_coord h);
        t_grid_req r;
        int gap;
        r   = '{kind, id, x, y, w, h};
        gap = next_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.kind;
        req_ch.object_id <= r.id;
        req_ch.rect_x    <= r.rect_x;
        req_ch.rect_y    <= r.rect_y;
        req_ch.rect_w    <= r.rect_w;
        req_ch.rect_h    <= r.rect_h;
        do @(posedge i_clk); while (!req_ch.ready);
        grid.take_request(r);
    endtask

    // Drop valid and hold until every owed response has come back
    task automatic hold_until_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (!grid.idle()) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cell_size(logic [ugb_pkg::SIZE_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        grid.set_edge(value);
        @(posedge i_clk);
    endtask

    // Random request: mostly small rectangles near the grid, a few huge ones
    task automatic send_random_request();
        int unsigned span, reach, stretch, r;
        logic [ugb_pkg::REQ_TYPE_W-1:0] kind;
        t_obj_id                        id;
        t_coord                         x, y, w, h;
        span    = (grid.edge_len == 0) ? 1 : 32'(grid.edge_len);
        reach   = span * (GRID_W + 1);
        reach   = (reach > COORD_MAX) ? COORD_MAX : reach;
        stretch = (2 * span > COORD_MAX) ? COORD_MAX : 2 * span;
        r = $urandom_range(0, 99);
        if (r < 35)
            kind = ugb_pkg::REQ_INSERT;
        else if (r < 55)
            kind = ugb_pkg::REQ_REMOVE;
        else if (r < 95)
            kind = ugb_pkg::REQ_QUERY;
        else
            kind = REQ_UNKNOWN;
        // Favour a few ids so that queries find overlaps
        id = ($urandom_range(0, 99) < 60) ? t_obj_id'($urandom_range(0, 15))
                                          : t_obj_id'($urandom_range(0, MAX_OBJECTS - 1));
        r = $urandom_range(0, 99);
        if (r < 80) begin
            x = t_coord'($urandom_range(0, reach));
            y = t_coord'($urandom_range(0, reach));
        end else begin
            x = t_coord'($urandom_range(0, COORD_MAX));
            y = t_coord'($urandom_range(0, COORD_MAX));
        end
        if (r < 96) begin
            w = t_coord'($urandom_range(0, stretch));
            h = t_coord'($urandom_range(0, stretch));
        end else begin
            w = t_coord'($urandom_range(0, COORD_MAX));
            h = t_coord'($urandom_range(0, COORD_MAX));
        end
        send_request(kind, id, x, y, w, h);
    endtask

    initial begin
        logic [ugb_pkg::SIZE_W-1:0] sizes [RANDOM_PHASES];
        grid        = new();
        calm        = 1'b0;
        sizes = '{12'd1, 12'd4095, 12'd0, 12'd64, 12'd13, 12'd300,
                  12'd2, 12'd64};
        sizes[6] = 12'($urandom_range(2, 4094));
        sizes[7] = 12'($urandom_range(2, 4094));

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= ugb_pkg::REQ_INSERT;
        req_ch.object_id <= '0;
        req_ch.rect_x    <= '0;
        req_ch.rect_y    <= '0;
        req_ch.rect_w    <= '0;
        req_ch.rect_h    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset cell size
        send_request(ugb_pkg::REQ_QUERY, 0, 0, 0, 4095, 4095);         // empty grid
        send_request(ugb_pkg::REQ_INSERT, 0, 0, 0, 0, 0);
        send_request(ugb_pkg::REQ_INSERT, 63, 4095, 4095, 4095, 4095); // far corner off the grid
        send_request(ugb_pkg::REQ_INSERT, 5, 100, 100, 200, 50);
        send_request(ugb_pkg::REQ_INSERT, 5, 100, 100, 200, 50);       // duplicate insert
        send_request(ugb_pkg::REQ_INSERT, 1, 63, 0, 1, 0);             // straddles a cell edge
        send_request(ugb_pkg::REQ_QUERY, 63, 0, 0, 0, 0);              // id ignored on query
        send_request(ugb_pkg::REQ_QUERY, 0, 64, 0, 0, 0);
        send_request(ugb_pkg::REQ_QUERY, 0, 4095, 0, 0, 4095);
        send_request(ugb_pkg::REQ_QUERY, 0, 0, 0, 4095, 4095);
        send_request(ugb_pkg::REQ_REMOVE, 7, 100, 100, 0, 0);          // absent id
        send_request(ugb_pkg::REQ_REMOVE, 5, 100, 100, 0, 0);          // clears one cell only
        send_request(ugb_pkg::REQ_QUERY, 0, 64, 64, 0, 0);
        send_request(ugb_pkg::REQ_QUERY, 0, 300, 150, 0, 0);
        send_request(REQ_UNKNOWN, 0, 0, 0, 4095, 4095);
        send_request(REQ_UNKNOWN, 63, 4095, 4095, 4095, 4095);
        send_request(ugb_pkg::REQ_INSERT, 42, 0, 2047, 4095, 0);
        send_request(ugb_pkg::REQ_REMOVE, 63, 0, 0, 4095, 4095);
        send_request(ugb_pkg::REQ_QUERY, 21, 2047, 2047, 2048, 2048);
        send_request(ugb_pkg::REQ_REMOVE, 0, 0, 0, 0, 0);
        send_request(ugb_pkg::REQ_QUERY, 0, 0, 0, 4095, 4095);
        hold_until_idle();

        // Random phases, one cell size each; one phase runs with no gaps
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm = (phase == 3);
            write_cell_size(sizes[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 199) == 0)
                    hold_until_idle();
                send_random_request();
            end
            hold_until_idle();
        end

        // Let any stray response show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (grid.errors == 0 && grid.idle())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
